@@ rtl/core/eyq_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the Euler-to-quaternion block.
package eyq_pkg;

    localparam int ANGLE_W   = 16;
    localparam int QUAT_W    = 16;
    localparam int TRIG_FRAC = 30;
    localparam int TRIG_W    = 32;
    localparam int ATAN_ENTRIES = 32;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // degree to binary angle: 2^22 / 45 = 93206 rem 34, remainder divided by 45 through its reciprocal
    localparam logic [16:0] DEG_SCALE_INT = 17'd93206;
    localparam logic [5:0]  DEG_SCALE_REM = 6'd34;
    localparam logic [4:0]  DEG_ROUND     = 5'd22;
    localparam logic [21:0] RECIP_45      = 22'd2982617;
    localparam int          RECIP_SHIFT   = 27;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle_x;
        logic signed [ANGLE_W-1:0] angle_y;
        logic signed [ANGLE_W-1:0] angle_z;
    } eyq_in_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } eyq_out_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } eyq_trig_t;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic signed [33:0] atan_turns(input int idx);
        logic signed [33:0] r;
        case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/eyq_trig_lane.sv @@
// One lane: half-angle conversion and pipelined CORDIC giving cosine and sine in Q1.30.
module eyq_trig_lane import eyq_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [ANGLE_W-1:0] angle,
    output eyq_trig_t                 trig
);
    localparam int N = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // stage 1: magnitude and the two partial scalings
    logic [16:0] mag;
    logic [33:0] p_int_reg;
    logic [20:0] v_reg;
    logic        neg1_reg;
    assign mag = angle[ANGLE_W-1] ? 17'(-$signed({angle[ANGLE_W-1], angle}))
                                  : 17'({1'b0, angle});
    always_ff @(posedge aclk) begin
        if (en) begin
            p_int_reg <= 34'(mag) * 34'(DEG_SCALE_INT);
            v_reg     <= 21'(21'(mag) * 21'(DEG_SCALE_REM) + 21'(DEG_ROUND));
            neg1_reg  <= angle[ANGLE_W-1];
        end
    end

    // stage 2: remainder divided by 45 through the reciprocal
    logic [42:0] p_rem;
    logic [33:0] p_int2_reg;
    logic [15:0] q_rem_reg;
    logic        neg2_reg;
    assign p_rem = 43'(v_reg) * 43'(RECIP_45);
    always_ff @(posedge aclk) begin
        if (en) begin
            p_int2_reg <= p_int_reg;
            q_rem_reg  <= p_rem[RECIP_SHIFT +: 16];
            neg2_reg   <= neg1_reg;
        end
    end

    // stage 3: binary angle, quadrant fold
    logic [31:0] units, t, tq, r;
    logic [1:0]  quad;
    assign units = p_int2_reg[31:0] + 32'(q_rem_reg);
    assign t     = neg2_reg ? (32'd0 - units) : units;
    assign tq    = t + 32'h2000_0000;
    assign quad  = tq[31:30];
    assign r     = t - {quad, 30'd0};

    logic signed [33:0] x_reg [0:N];
    logic signed [33:0] y_reg [0:N];
    logic signed [33:0] z_reg [0:N];
    logic [1:0]         q_reg [0:N];
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= CORDIC_GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= 34'($signed(r));
            q_reg[0] <= quad;
        end
    end

    // rotation iterations, one per stage
    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [33:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][33]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_turns(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_turns(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // quadrant restore
    eyq_trig_t trig_next, trig_reg;
    always_comb begin
        case (q_reg[N])
            QUAD_0: begin
                trig_next.cos_v = TRIG_W'(x_reg[N]);
                trig_next.sin_v = TRIG_W'(y_reg[N]);
            end
            QUAD_1: begin
                trig_next.cos_v = TRIG_W'(-y_reg[N]);
                trig_next.sin_v = TRIG_W'(x_reg[N]);
            end
            QUAD_2: begin
                trig_next.cos_v = TRIG_W'(-x_reg[N]);
                trig_next.sin_v = TRIG_W'(-y_reg[N]);
            end
            default: begin
                trig_next.cos_v = TRIG_W'(y_reg[N]);
                trig_next.sin_v = TRIG_W'(-x_reg[N]);
            end
        endcase
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg <= trig_next;
        end
    end
    assign trig = trig_reg;

endmodule

@@ rtl/core/eyq_merge.sv @@
// Merge stage: combines the three lanes' sines and cosines into the quaternion.
module eyq_merge import eyq_pkg::*; #(
    parameter int FRAC = 14
) (
    input  logic      aclk,
    input  logic      en,
    input  eyq_trig_t tx,
    input  eyq_trig_t ty,
    input  eyq_trig_t tz,
    output eyq_out_t  quat
);
    localparam int SH = 2 * TRIG_FRAC - FRAC;

    function automatic logic signed [TRIG_W-1:0] rmul(input logic signed [TRIG_W-1:0] a,
                                                      input logic signed [TRIG_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< (TRIG_FRAC - 1));
        return TRIG_W'(p >>> TRIG_FRAC);
    endfunction

    function automatic logic signed [QUAT_W-1:0] fin(input logic signed [64:0] v);
        logic signed [64:0] r;
        r = (v + (65'sd1 <<< (SH - 1))) >>> SH;
        if (r > 65'sd32767)       return 16'sh7fff;
        else if (r < -65'sd32768) return 16'sh8000;
        else                      return QUAT_W'(r);
    endfunction

    // stage 1: pair Y with Z
    logic signed [TRIG_W-1:0] sysz_reg, cycz_reg, sycz_reg, cysz_reg, cx1_reg, sx1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sysz_reg <= rmul(ty.sin_v, tz.sin_v);
            cycz_reg <= rmul(ty.cos_v, tz.cos_v);
            sycz_reg <= rmul(ty.sin_v, tz.cos_v);
            cysz_reg <= rmul(ty.cos_v, tz.sin_v);
            cx1_reg  <= tx.cos_v;
            sx1_reg  <= tx.sin_v;
        end
    end

    // stage 2: full products with X
    logic signed [63:0] pr_reg [0:7];
    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0] <= 64'(cycz_reg) * 64'(cx1_reg);
            pr_reg[1] <= 64'(sysz_reg) * 64'(sx1_reg);
            pr_reg[2] <= 64'(sysz_reg) * 64'(cx1_reg);
            pr_reg[3] <= 64'(cycz_reg) * 64'(sx1_reg);
            pr_reg[4] <= 64'(sycz_reg) * 64'(cx1_reg);
            pr_reg[5] <= 64'(cysz_reg) * 64'(sx1_reg);
            pr_reg[6] <= 64'(cysz_reg) * 64'(cx1_reg);
            pr_reg[7] <= 64'(sycz_reg) * 64'(sx1_reg);
        end
    end

    // stage 3: sums, rounding, saturation into the output register
    eyq_out_t quat_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            quat_reg.quat_w <= fin(65'(pr_reg[0]) - 65'(pr_reg[1]));
            quat_reg.quat_x <= fin(65'(pr_reg[2]) + 65'(pr_reg[3]));
            quat_reg.quat_y <= fin(65'(pr_reg[4]) + 65'(pr_reg[5]));
            quat_reg.quat_z <= fin(65'(pr_reg[6]) - 65'(pr_reg[7]));
        end
    end
    assign quat = quat_reg;

endmodule

@@ rtl/core/euler_yxz_to_quaternion.sv @@
// Top level: Euler angles (Y-X-Z order) to unit quaternion, three trig lanes and a merge stage.
//
// Input beat s_data carries angle_x, angle_y, angle_z in 1/64 degree, two's complement.
// Output beat m_data carries quat_w, quat_x, quat_y, quat_z, signed with OUT_FRAC_BITS
// fractional bits, rounded and saturated to 16 bits.
// Both channels are valid/ready; a beat moves when valid and ready are high at an edge.
// Throughput: one beat per cycle with m_ready high. Each angle runs in its own lane through a
// fully pipelined CORDIC, one iteration per stage, so the pipeline sets the rate.
// Pipeline from input beat to output beat: three conversion stages, TRIG_STEPS
// CORDIC stages (capped at ATAN_ENTRIES), a quadrant stage and three merge stages,
// the last of which is the output register.
// When the receiver holds m_ready low with a beat waiting, the whole pipeline
// holds and s_ready drops; any bubbles ahead of the output keep flowing in only
// once the output register moves. Beats in flight are never lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline; no state is kept
// between beats.
module euler_yxz_to_quaternion import eyq_pkg::*; #(
    parameter int OUT_FRAC_BITS = 14,
    parameter int TRIG_STEPS    = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  eyq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output eyq_out_t m_data
);
    localparam int N   = (TRIG_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_STEPS;
    localparam int LAT = N + 7;

    logic en;
    logic [LAT-1:0] vld_reg, vld_next;
    eyq_trig_t tx, ty, tz;

    // pipeline advances unless a finished beat is stuck at the output
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    // valid tracking along the pipeline
    assign vld_next = {vld_reg[LAT-2:0], s_valid};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // one lane per angle
    eyq_trig_lane #(.STEPS(TRIG_STEPS)) u_lane_x (
        .aclk(aclk), .en(en), .angle(s_data.angle_x), .trig(tx));
    eyq_trig_lane #(.STEPS(TRIG_STEPS)) u_lane_y (
        .aclk(aclk), .en(en), .angle(s_data.angle_y), .trig(ty));
    eyq_trig_lane #(.STEPS(TRIG_STEPS)) u_lane_z (
        .aclk(aclk), .en(en), .angle(s_data.angle_z), .trig(tz));

    eyq_merge #(.FRAC(OUT_FRAC_BITS)) u_merge (
        .aclk(aclk), .en(en), .tx(tx), .ty(ty), .tz(tz), .quat(m_data));

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled output beat changed");
`endif

endmodule
